### hdl/e2g_pkg.sv
// ----------------------------------------------------------------------------
// e2g_pkg: shared definitions for the ECEF to geodetic converter
// Field widths, WGS84 constants in fixed point, the request bundle of the
// square root / divider unit and the CORDIC arctangent table generator.
// ----------------------------------------------------------------------------
package e2g_pkg;

  localparam int XYZ_W      = 36;
  localparam int ANG_OUT_W  = 32;
  localparam int TOL_W      = 10;
  localparam int LIM_W      = 7;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 10;
  localparam int S_DATA_W   = 112;
  localparam int M_DATA_W   = 104;
  localparam int M_USER_W   = 2;
  localparam int SQ_W       = 106;

  localparam int ANGLE_BITS_DEF    = 32;
  localparam int CORDIC_STAGES_DEF = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_TOL   = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LIMIT = 1'd1;

  localparam logic [TOL_W-1:0] TOL_RESET   = 10'd1;
  localparam logic [LIM_W-1:0] LIMIT_RESET = 7'd8;

  // Q60 constants and the equatorial radius in Q16 millimetres.
  localparam logic [63:0] ECC2_Q60 = 64'd7718094650642178;
  localparam logic [63:0] ONE_Q60  = 64'd1 << 60;
  localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
  localparam logic [63:0] A_Q16    = 64'd6378137000 << 16;
  localparam logic signed [XYZ_W-1:0] INVALID_HEIGHT = -36'sd6378137000;

  typedef struct packed {
    logic start;
    logic is_div;
  } sd_req_t;

  // atan(2^-idx)/(2*pi) scaled to abits bits, from a truncated Taylor series in
  // Q60 and a long division by pi. Evaluated at elaboration only.
  function automatic logic [63:0] e2g_atan_entry(input int idx, input int abits);
    logic [63:0] acc;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] term;
    logic [63:0] rr;
    logic [63:0] r;
    logic [63:0] q;
    int k;
    int e;
    int b;
    if (idx == 0) begin
      return 64'd1 << (abits - 3);
    end
    acc = '0;
    k = 0;
    e = idx;
    while (e <= 60) begin
      num  = 64'd1 << (60 - e);
      den  = 64'(2 * k + 1);
      term = '0;
      rr   = '0;
      for (b = 63; b >= 0; b--) begin
        rr   = {rr[62:0], num[b]};
        term = {term[62:0], 1'b0};
        if (rr >= den) begin
          rr   = rr - den;
          term = term | 64'd1;
        end
      end
      if ((k % 2) == 1) acc = acc - term;
      else acc = acc + term;
      k = k + 1;
      e = idx * (2 * k + 1);
    end
    r = acc;
    q = '0;
    for (b = 0; b < abits; b++) begin
      r = {r[62:0], 1'b0};
      q = {q[62:0], 1'b0};
      if (r >= PI_Q60) begin
        r = r - PI_Q60;
        q = q | 64'd1;
      end
    end
    return (q + 64'd1) >> 1;
  endfunction

  function automatic logic [63:0] e2g_abs64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

endpackage

### hdl/e2g_mul.sv
// ----------------------------------------------------------------------------
// e2g_mul: iterative 64 x 64 unsigned multiplier
// Four 32 x 32 partial products, one per cycle, registered and then summed
// into a 128-bit accumulator. Result valid with the done pulse.
// ----------------------------------------------------------------------------
module e2g_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] p
);
  import e2g_pkg::*;

  logic [63:0]  ar;
  logic [63:0]  br;
  logic [2:0]   cnt;
  logic         active;
  logic [63:0]  pp;
  logic [1:0]   pp_sh;
  logic [127:0] acc;
  logic [31:0]  a_h;
  logic [31:0]  b_h;
  logic [127:0] term;

  assign a_h  = cnt[1] ? ar[63:32] : ar[31:0];
  assign b_h  = cnt[0] ? br[63:32] : br[31:0];
  assign term = {64'd0, pp} << {pp_sh, 5'd0};
  assign p    = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
      end else if (active && cnt == 3'd4) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ar  <= a;
      br  <= b;
      cnt <= '0;
      acc <= '0;
    end else if (active) begin
      cnt   <= cnt + 3'd1;
      pp    <= a_h * b_h;
      pp_sh <= {1'b0, cnt[1]} + {1'b0, cnt[0]};
      if (cnt != 3'd0) begin
        acc <= acc + term;
      end
    end
  end

endmodule

### hdl/e2g_sqdiv.sv
// ----------------------------------------------------------------------------
// e2g_sqdiv: shift-subtract square root and fractional divider
// One compare/subtract per cycle. Square root: 64 steps over a 128-bit
// radicand. Division: an integer step (numerator below twice the divisor)
// and then 60 fraction bits; a zero divisor returns zero.
// ----------------------------------------------------------------------------
module e2g_sqdiv (
  input  logic                   clk,
  input  logic                   rst,
  input  e2g_pkg::sd_req_t       req,
  input  logic [127:0]           rad,
  input  logic [63:0]            den,
  output logic                   done,
  output logic [63:0]            result
);
  import e2g_pkg::*;

  localparam int LW = 68;

  logic [65:0]   rem;
  logic [63:0]   quo;
  logic [127:0]  radsh;
  logic [63:0]   dreg;
  logic [6:0]    cnt;
  logic          active;
  logic          is_div;
  logic          first;
  logic          zden;
  logic [LW-1:0] lhs;
  logic [LW-1:0] rhs;
  logic [LW:0]   diff;
  logic          ge;
  logic [6:0]    last;

  always_comb begin
    if (is_div) begin
      lhs = first ? LW'(rem) : LW'({rem, 1'b0});
      rhs = LW'(dreg);
    end else begin
      lhs = {rem, radsh[127:126]};
      rhs = LW'({quo, 2'b01});
    end
  end

  assign diff   = {1'b0, lhs} - {1'b0, rhs};
  assign ge     = ~diff[LW];
  assign last   = is_div ? 7'd60 : 7'd63;
  assign result = (is_div && zden) ? 64'd0 : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        active <= 1'b1;
      end else if (active && cnt == last) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      is_div <= req.is_div;
      first  <= 1'b1;
      cnt    <= '0;
      quo    <= '0;
      rem    <= req.is_div ? 66'(rad[63:0]) : 66'd0;
      radsh  <= rad;
      dreg   <= den;
      zden   <= (den == 64'd0);
    end else if (active) begin
      rem   <= ge ? diff[65:0] : lhs[65:0];
      quo   <= {quo[62:0], ge};
      radsh <= radsh << 2;
      first <= 1'b0;
      cnt   <= cnt + 7'd1;
    end
  end

endmodule

### hdl/ecef_to_geodetic.sv
// ----------------------------------------------------------------------------
// ecef_to_geodetic: Earth-centred position to WGS84 latitude, longitude, height
// Iterative z-correction method in fixed point. A small sequencer drives one
// shared multiplier, one shift-subtract square root / divider and a CORDIC
// vectoring stage.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                         | Item contents (low bits first)
//  ---------+---------------------------------+-----------------------------------
//  input    | s_tvalid s_tready s_tdata       | x_mm, y_mm, z_mm (36 b each), 0 pad
//  output   | m_tvalid m_tready m_tdata       | latitude, longitude, height_mm, pad
//           | m_tuser                         | invalid, not_converged
//  config   | cfg_wen cfg_addr cfg_wdata      | 0 tolerance_mm, 1 iteration_limit
//
// An item takes a setup, then correction iterations (each with two square
// roots, two divisions and five multiplies), and two CORDIC vectoring passes
// for the angles. The shift-subtract unit produces one result bit per cycle.
// A short vector is finished after the setup multiplies.
// s_tready is high only while the sequencer is idle; one item is in work.
// A finished result waits in the output register while the next item is
// accepted; the sequencer stalls at its last step only if that register is
// still full. Reset is synchronous and loads the register defaults.
module ecef_to_geodetic #(
  parameter int ANGLE_BITS    = e2g_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = e2g_pkg::CORDIC_STAGES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // x_mm [35:0], y_mm [71:36], z_mm [107:72], zero [111:108]
  input  logic [e2g_pkg::S_DATA_W-1:0]   s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // latitude [31:0], longitude [63:32], height_mm [99:64], zero [103:100]
  output logic [e2g_pkg::M_DATA_W-1:0]   m_tdata,
  // invalid [0], not_converged [1]
  output logic [e2g_pkg::M_USER_W-1:0]   m_tuser,
  input  logic                           cfg_wen,
  input  logic [e2g_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [e2g_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import e2g_pkg::*;

  localparam int CS_W = $clog2(CORDIC_STAGES);
  localparam logic [CS_W-1:0] LAST_STAGE = CS_W'(CORDIC_STAGES - 1);

  typedef enum logic [22:0] {
    ST_IDLE     = 23'd1 << 0,
    ST_SQX      = 23'd1 << 1,
    ST_SQY      = 23'd1 << 2,
    ST_SQZ      = 23'd1 << 3,
    ST_TOL      = 23'd1 << 4,
    ST_CHECK    = 23'd1 << 5,
    ST_RADIAL   = 23'd1 << 6,
    ST_CORR     = 23'd1 << 7,
    ST_ZC       = 23'd1 << 8,
    ST_HYP      = 23'd1 << 9,
    ST_SIN      = 23'd1 << 10,
    ST_S2       = 23'd1 << 11,
    ST_W        = 23'd1 << 12,
    ST_ROOT     = 23'd1 << 13,
    ST_PRIME    = 23'd1 << 14,
    ST_NE2      = 23'd1 << 15,
    ST_NEXT     = 23'd1 << 16,
    ST_CONV     = 23'd1 << 17,
    ST_LAT_PRE  = 23'd1 << 18,
    ST_LAT      = 23'd1 << 19,
    ST_LON_PRE  = 23'd1 << 20,
    ST_LON      = 23'd1 << 21,
    ST_HEIGHT   = 23'd1 << 22
  } state_t;

  state_t state;

  // Configuration registers.
  logic [TOL_W-1:0] tol;
  logic [LIM_W-1:0] limit;

  // Working registers, lengths in Q16 millimetres.
  logic signed [63:0] xq, yq, zq;
  logic [SQ_W-1:0]    rsq, zsq, hsq;
  logic [19:0]        tsq;
  logic [63:0]        radial, hyp, sl, s2, w, root, prime, ne2;
  logic signed [63:0] corr, zc, next_v;
  logic [LIM_W-1:0]   it;
  logic               issued;

  // CORDIC registers.
  logic signed [63:0]    cx, cy;
  logic [ANGLE_BITS-1:0] cang;
  logic [CS_W-1:0]       cstage;
  logic                  cz;

  // Result registers.
  logic [ANG_OUT_W-1:0]    res_lat;
  logic                    res_inv, res_nc;

  // Unit connections.
  logic         mul_start, mul_done;
  logic [63:0]  mul_a, mul_b;
  logic [127:0] mul_p;
  logic [63:0]  shr60;
  sd_req_t      sd_req;
  logic [127:0] sd_rad;
  logic [63:0]  sd_den;
  logic         sd_done;
  logic [63:0]  sd_res;
  logic         mul_state, sd_state;

  e2g_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  e2g_sqdiv u_sqdiv (
    .clk    (clk),
    .rst    (rst),
    .req    (sd_req),
    .rad    (sd_rad),
    .den    (sd_den),
    .done   (sd_done),
    .result (sd_res)
  );

  assign shr60 = mul_p[123:60];

  // Magnitudes and the current corrected z.
  logic [63:0]        ax, ay, az, azc;
  logic signed [63:0] zc_w;
  assign ax   = e2g_abs64(xq);
  assign ay   = e2g_abs64(yq);
  assign az   = e2g_abs64(zq);
  assign zc_w = zq + corr;
  assign azc  = e2g_abs64(zc);

  assign mul_state = (state == ST_SQX) || (state == ST_SQY) || (state == ST_SQZ) ||
                     (state == ST_TOL) || (state == ST_CORR) || (state == ST_ZC) ||
                     (state == ST_S2) || (state == ST_W) || (state == ST_NE2) ||
                     (state == ST_NEXT);
  assign sd_state  = (state == ST_RADIAL) || (state == ST_HYP) || (state == ST_SIN) ||
                     (state == ST_ROOT) || (state == ST_PRIME);

  assign mul_start     = mul_state && !issued;
  assign sd_req.start  = sd_state && !issued;
  assign sd_req.is_div = (state == ST_SIN) || (state == ST_PRIME);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SQX:  begin mul_a = ax;                 mul_b = ax;       end
      ST_SQY:  begin mul_a = ay;                 mul_b = ay;       end
      ST_SQZ:  begin mul_a = az;                 mul_b = az;       end
      ST_TOL:  begin mul_a = 64'(tol);           mul_b = 64'(tol); end
      ST_CORR: begin mul_a = az;                 mul_b = ECC2_Q60; end
      ST_ZC:   begin mul_a = e2g_abs64(zc_w);    mul_b = e2g_abs64(zc_w); end
      ST_S2:   begin mul_a = sl;                 mul_b = sl;       end
      ST_W:    begin mul_a = ECC2_Q60;           mul_b = s2;       end
      ST_NE2:  begin mul_a = prime;              mul_b = ECC2_Q60; end
      ST_NEXT: begin mul_a = ne2;                mul_b = sl;       end
      default: begin mul_a = '0;                 mul_b = '0;       end
    endcase
  end

  always_comb begin
    sd_rad = '0;
    sd_den = '0;
    case (state)
      ST_RADIAL: sd_rad = 128'(rsq);
      ST_HYP:    sd_rad = 128'(hsq);
      ST_SIN:    begin sd_rad = 128'(azc);   sd_den = hyp;  end
      ST_ROOT:   sd_rad = {4'd0, w, 60'd0};
      ST_PRIME:  begin sd_rad = 128'(A_Q16); sd_den = root; end
      default:   begin sd_rad = '0;          sd_den = '0;   end
    endcase
  end

  // Short-vector test: every component below 1024 mm and the squared length
  // below the squared tolerance. The Q16 squares carry 32 zero fraction bits.
  logic [SQ_W-1:0] total_sq;
  logic            short_vec;
  assign total_sq  = rsq + zsq;
  assign short_vec = (ax[63:26] == '0) && (ay[63:26] == '0) && (az[63:26] == '0) &&
                     (total_sq[SQ_W-1:32] < (SQ_W-32)'(tsq));

  // Convergence test on the change of the correction term.
  logic signed [63:0] dlt;
  logic [LIM_W-1:0]   lim_eff;
  logic               conv_hit;
  assign dlt      = corr - next_v;
  assign conv_hit = e2g_abs64(dlt) < {38'd0, tol, 16'd0};
  assign lim_eff  = (limit == '0) ? LIM_W'(1) : limit;

  // CORDIC arctangent table and one vectoring step.
  logic [ANGLE_BITS-1:0] atan_tab [CORDIC_STAGES];
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_atan
    assign atan_tab[g] = ANGLE_BITS'(e2g_atan_entry(g, ANGLE_BITS));
  end

  logic signed [63:0] dx, dy;
  assign dx = cy >>> cstage;
  assign dy = cx >>> cstage;

  // Operand load for a vectoring pass: a zero vector gives angle zero, a
  // vector in the left half plane is turned by half a turn first.
  logic signed [63:0] ld_x, ld_y;
  assign ld_x = (state == ST_LAT_PRE) ? $signed(radial) : xq;
  assign ld_y = (state == ST_LAT_PRE) ? zc : yq;

  // Angle to 32 bits, rounding half up when the angle register is wider.
  logic [ANGLE_BITS-1:0] cang_eff;
  logic [ANG_OUT_W-1:0]  ang32;
  assign cang_eff = cz ? '0 : cang;
  if (ANGLE_BITS > ANG_OUT_W) begin : g_ang_round
    logic [ANGLE_BITS:0] rsum;
    assign rsum  = {1'b0, cang_eff} + ((ANGLE_BITS + 1)'(1) << (ANGLE_BITS - ANG_OUT_W - 1));
    assign ang32 = rsum[ANGLE_BITS-1:ANGLE_BITS-ANG_OUT_W];
  end else if (ANGLE_BITS == ANG_OUT_W) begin : g_ang_same
    assign ang32 = cang_eff;
  end else begin : g_ang_pad
    assign ang32 = {cang_eff, {(ANG_OUT_W - ANGLE_BITS){1'b0}}};
  end

  // Height = hyp - prime, rounded half up to whole millimetres, saturated.
  logic signed [64:0] hgt, hrnd;
  logic signed [48:0] hmm;
  assign hgt  = $signed({1'b0, hyp}) - $signed({1'b0, prime});
  assign hrnd = hgt + 65'sd32768;
  assign hmm  = hrnd[64:16];

  // Saturated height in millimetres.
  logic signed [XYZ_W-1:0] sat_h;
  always_comb begin
    if (hmm > 49'sd34359738367) sat_h = 36'sh7FFFFFFFF;
    else if (hmm < -49'sd34359738368) sat_h = 36'sh800000000;
    else sat_h = hmm[XYZ_W-1:0];
  end

  assign s_tready = (state == ST_IDLE);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      tol   <= TOL_RESET;
      limit <= LIMIT_RESET;
    end else if (cfg_wen) begin
      case (cfg_addr)
        REG_TOL:   tol   <= cfg_wdata[TOL_W-1:0];
        REG_LIMIT: limit <= cfg_wdata[LIM_W-1:0];
        default:   tol   <= tol;
      endcase
    end
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      issued   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (mul_start || sd_req.start) begin
        issued <= 1'b1;
      end else if (mul_done || sd_done) begin
        issued <= 1'b0;
      end
      // A new result is loaded when the output register is empty or drains.
      if (state == ST_HEIGHT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE:    if (s_tvalid) state <= ST_SQX;
        ST_SQX:     if (mul_done) state <= ST_SQY;
        ST_SQY:     if (mul_done) state <= ST_SQZ;
        ST_SQZ:     if (mul_done) state <= ST_TOL;
        ST_TOL:     if (mul_done) state <= ST_CHECK;
        ST_CHECK:   state <= short_vec ? ST_HEIGHT : ST_RADIAL;
        ST_RADIAL:  if (sd_done) state <= ST_CORR;
        ST_CORR:    if (mul_done) state <= ST_ZC;
        ST_ZC:      if (mul_done) state <= ST_HYP;
        ST_HYP:     if (sd_done) state <= ST_SIN;
        ST_SIN:     if (sd_done) state <= ST_S2;
        ST_S2:      if (mul_done) state <= ST_W;
        ST_W:       if (mul_done) state <= ST_ROOT;
        ST_ROOT:    if (sd_done) state <= ST_PRIME;
        ST_PRIME:   if (sd_done) state <= ST_NE2;
        ST_NE2:     if (mul_done) state <= ST_NEXT;
        ST_NEXT:    if (mul_done) state <= ST_CONV;
        ST_CONV: begin
          if (conv_hit || (it + LIM_W'(1)) == lim_eff) state <= ST_LAT_PRE;
          else state <= ST_ZC;
        end
        ST_LAT_PRE: state <= ST_LAT;
        ST_LAT:     if (cstage == LAST_STAGE) state <= ST_LON_PRE;
        ST_LON_PRE: state <= ST_LON;
        ST_LON:     if (cstage == LAST_STAGE) state <= ST_HEIGHT;
        ST_HEIGHT: begin
          // The short-vector path also finishes here with its fixed result.
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default:    state <= ST_IDLE;
      endcase
    end
  end

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        xq  <= {{12{s_tdata[35]}},  s_tdata[35:0],   16'd0};
        yq  <= {{12{s_tdata[71]}},  s_tdata[71:36],  16'd0};
        zq  <= {{12{s_tdata[107]}}, s_tdata[107:72], 16'd0};
        it  <= '0;
      end
      ST_SQX:   if (mul_done) rsq <= mul_p[SQ_W-1:0];
      ST_SQY:   if (mul_done) rsq <= rsq + mul_p[SQ_W-1:0];
      ST_SQZ:   if (mul_done) zsq <= mul_p[SQ_W-1:0];
      ST_TOL:   if (mul_done) tsq <= mul_p[19:0];
      ST_CHECK: begin
        res_lat <= '0;
        res_inv <= short_vec;
        res_nc  <= 1'b0;
      end
      ST_RADIAL: if (sd_done) radial <= sd_res;
      ST_CORR:   if (mul_done) corr <= zq[63] ? -$signed(shr60) : $signed(shr60);
      ST_ZC: begin
        if (mul_done) begin
          zc  <= zc_w;
          hsq <= mul_p[SQ_W-1:0] + rsq;
        end
      end
      ST_HYP:   if (sd_done) hyp <= sd_res;
      ST_SIN:   if (sd_done) sl <= (sd_res > ONE_Q60) ? ONE_Q60 : sd_res;
      ST_S2:    if (mul_done) s2 <= shr60;
      ST_W:     if (mul_done) w <= ONE_Q60 - shr60;
      ST_ROOT:  if (sd_done) root <= sd_res;
      ST_PRIME: if (sd_done) prime <= sd_res;
      ST_NE2:   if (mul_done) ne2 <= shr60;
      ST_NEXT:  if (mul_done) next_v <= zc[63] ? -$signed(shr60) : $signed(shr60);
      ST_CONV: begin
        if (conv_hit) begin
          res_nc <= 1'b0;
        end else begin
          corr   <= next_v;
          it     <= it + LIM_W'(1);
          res_nc <= 1'b1;
        end
      end
      ST_LAT_PRE, ST_LON_PRE: begin
        if (state == ST_LON_PRE) res_lat <= ang32;
        cz     <= (ld_x == '0) && (ld_y == '0);
        cx     <= ld_x[63] ? -ld_x : ld_x;
        cy     <= ld_x[63] ? -ld_y : ld_y;
        cang   <= ld_x[63] ? (ANGLE_BITS'(1) << (ANGLE_BITS - 1)) : '0;
        cstage <= '0;
      end
      ST_LAT, ST_LON: begin
        if (!cy[63]) begin
          cx   <= cx + dx;
          cy   <= cy - dy;
          cang <= cang + atan_tab[cstage];
        end else begin
          cx   <= cx - dx;
          cy   <= cy + dy;
          cang <= cang - atan_tab[cstage];
        end
        cstage <= cstage + CS_W'(1);
      end
      ST_HEIGHT: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= res_inv ? {4'd0, INVALID_HEIGHT, 64'd0}
                             : {4'd0, sat_h, ang32, res_lat};
          m_tuser <= res_inv ? 2'b01 : {res_nc, 1'b0};
        end
      end
      default: it <= it;
    endcase
  end

  // The multiplier and the shift-subtract unit are never launched together.
  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(mul_start && sd_req.start))
    else $error("both arithmetic units launched in one cycle");

  // An accepted item keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready right after an accepted item");

  // A short vector never reports non-convergence.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("invalid and not-converged both set");

  // A short vector gives zero angles.
  a_invalid_angles: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[63:0] == 64'd0))
    else $error("invalid result with nonzero angles");

  // The multiplier only completes while its multiply state is still current.
  a_done_in_state: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> mul_state)
    else $error("multiplier finished outside a multiply step");

endmodule
